// ===== rtl/ptmr_pkg.sv =====
// Package for the post-trigger magnitude range unit.
// Holds payload structs, status codes, state types and fixed widths; no dependencies.
`timescale 1ns / 1ps

package ptmr_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int INDEX_BITS  = 16;
	localparam int RAD_BITS    = 2 * SAMPLE_BITS;
	localparam int REM_BITS    = SAMPLE_BITS + 3;
	localparam int CNT_BITS    = $clog2(SAMPLE_BITS);

	localparam logic [1:0] ST_WAITING  = 2'd0;
	localparam logic [1:0] ST_GAP      = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;

	localparam logic ACT_TRIGGER = 1'b0;

	typedef struct packed {
		logic                          action;
		logic                          gap;
		logic signed [SAMPLE_BITS-1:0] vel_z;
		logic signed [SAMPLE_BITS-1:0] vel_n;
		logic signed [SAMPLE_BITS-1:0] vel_e;
		logic signed [SAMPLE_BITS-1:0] acc_z;
		logic signed [SAMPLE_BITS-1:0] acc_n;
		logic signed [SAMPLE_BITS-1:0] acc_e;
	} in_item_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [SAMPLE_BITS-1:0] vel_min;
		logic [SAMPLE_BITS-1:0] vel_max;
		logic [SAMPLE_BITS-1:0] acc_min;
		logic [SAMPLE_BITS-1:0] acc_max;
	} out_item_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SUM,
		SQ_ROOT,
		SQ_DONE
	} sq_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_CHECK,
		T_VEL,
		T_ACC,
		T_APPLY
	} top_state_t;

endpackage

// ===== rtl/post_trigger_magnitude_range_unit.sv =====
// Top level of the post-trigger magnitude range unit.
// Channel     | direction | payload    | handshake
// in          | input     | in_item_t  | in_valid / in_stall
// out         | output    | out_item_t | out_valid / out_stall
// apb         | input     | 16-bit reg | psel, penable, pwrite, pready
// Items outside the window, triggers and gap samples go from transfer to result without the root unit.
// In-window samples send two magnitudes through the shared square root
// unit, each by squaring the components and then resolving one root bit per cycle.
// One item is in work at a time; the next transfer is taken once the result is registered.
// A stalled result holds in the output register. Reset clears measurement and windows 10/20.
// Depends on ptmr_pkg and ptmr_mag.
`timescale 1ns / 1ps

module post_trigger_magnitude_range_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ptmr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ptmr_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int SB = ptmr_pkg::SAMPLE_BITS;
	localparam int IB = ptmr_pkg::INDEX_BITS;

	ptmr_pkg::top_state_t state_q, state_d;

	logic [IB-1:0] win_start_q, win_end_q;
	logic [1:0]    meas_status_q;
	logic [IB-1:0] sample_index_q;
	logic [SB-1:0] vel_low_q, vel_high_q, acc_low_q, acc_high_q;
	logic [SB-1:0] vel_mag_q;
	ptmr_pkg::in_item_t  item_q;
	ptmr_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic          need;
	logic          sq_start, sq_done;
	logic [SB-1:0] sq_root;
	logic          apply_now;
	logic          slot_free;
	logic          cfg_wr;

	logic [1:0]    status_d;
	logic [IB-1:0] index_d;
	logic [SB-1:0] vel_low_d, vel_high_d, acc_low_d, acc_high_d;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = paddr[2] ? 32'(win_end_q) : 32'(win_start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= IB'(10);
			win_end_q   <= IB'(20);
		end else if (cfg_wr) begin
			if (paddr[2]) win_end_q <= pwdata[IB-1:0];
			else win_start_q <= pwdata[IB-1:0];
		end
	end

	assign need = (item_q.action != ptmr_pkg::ACT_TRIGGER)
		&& (meas_status_q == ptmr_pkg::ST_WAITING) && !item_q.gap
		&& (sample_index_q >= win_start_q) && (sample_index_q <= win_end_q);

	assign slot_free = !out_valid_q || !out_stall;

	ptmr_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.a      ((state_q == ptmr_pkg::T_VEL) ? item_q.acc_z : item_q.vel_z),
		.b      ((state_q == ptmr_pkg::T_VEL) ? item_q.acc_n : item_q.vel_n),
		.c      ((state_q == ptmr_pkg::T_VEL) ? item_q.acc_e : item_q.vel_e),
		.done   (sq_done),
		.root   (sq_root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptmr_pkg::T_IDLE: begin
				if (in_valid) state_d = ptmr_pkg::T_CHECK;
			end
			ptmr_pkg::T_CHECK: begin
				state_d = need ? ptmr_pkg::T_VEL : ptmr_pkg::T_APPLY;
			end
			ptmr_pkg::T_VEL: begin
				if (sq_done) state_d = ptmr_pkg::T_ACC;
			end
			ptmr_pkg::T_ACC: begin
				if (sq_done) state_d = ptmr_pkg::T_APPLY;
			end
			ptmr_pkg::T_APPLY: begin
				if (slot_free) state_d = ptmr_pkg::T_IDLE;
			end
			default: state_d = ptmr_pkg::T_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = 1'b1;
		sq_start  = 1'b0;
		apply_now = 1'b0;
		unique case (state_q)
			ptmr_pkg::T_IDLE:  in_stall = 1'b0;
			ptmr_pkg::T_CHECK: sq_start = need;
			ptmr_pkg::T_VEL:   sq_start = sq_done;
			ptmr_pkg::T_ACC:   ;
			ptmr_pkg::T_APPLY: apply_now = slot_free;
			default: ;
		endcase
	end

	// measurement update for the held item
	always_comb begin
		status_d   = meas_status_q;
		index_d    = sample_index_q;
		vel_low_d  = vel_low_q;
		vel_high_d = vel_high_q;
		acc_low_d  = acc_low_q;
		acc_high_d = acc_high_q;
		priority if (item_q.action == ptmr_pkg::ACT_TRIGGER) begin
			status_d   = ptmr_pkg::ST_WAITING;
			index_d    = '0;
			vel_low_d  = '0;
			vel_high_d = '0;
			acc_low_d  = '0;
			acc_high_d = '0;
		end else if (meas_status_q == ptmr_pkg::ST_WAITING) begin
			if (item_q.gap) begin
				status_d = ptmr_pkg::ST_GAP;
			end else begin
				if (need) begin
					// min follows any value while the max is still zero
					if (vel_high_q == '0 || vel_mag_q < vel_low_q) vel_low_d = vel_mag_q;
					if (vel_high_q < vel_mag_q) vel_high_d = vel_mag_q;
					if (acc_high_q == '0 || sq_root < acc_low_q) acc_low_d = sq_root;
					if (acc_high_q < sq_root) acc_high_d = sq_root;
				end
				if (sample_index_q >= win_end_q) status_d = ptmr_pkg::ST_COMPLETE;
				if (sample_index_q != '1) index_d = sample_index_q + IB'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ptmr_pkg::T_IDLE;
			out_valid_q    <= 1'b0;
			meas_status_q  <= ptmr_pkg::ST_WAITING;
			sample_index_q <= '0;
			vel_low_q      <= '0;
			vel_high_q     <= '0;
			acc_low_q      <= '0;
			acc_high_q     <= '0;
		end else begin
			state_q <= state_d;
			if (apply_now) begin
				out_valid_q    <= 1'b1;
				meas_status_q  <= status_d;
				sample_index_q <= index_d;
				vel_low_q      <= vel_low_d;
				vel_high_q     <= vel_high_d;
				acc_low_q      <= acc_low_d;
				acc_high_q     <= acc_high_d;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_q <= in_data;
		if (state_q == ptmr_pkg::T_VEL && sq_done) vel_mag_q <= sq_root;
		if (apply_now) begin
			out_q.status  <= status_d;
			out_q.vel_min <= vel_low_d;
			out_q.vel_max <= vel_high_d;
			out_q.acc_min <= acc_low_d;
			out_q.acc_max <= acc_high_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/ptmr_mag.sv =====
// Iterative vector magnitude: floor(sqrt(a^2 + b^2 + c^2)).
// One shared multiplier sums the squares, then one root bit is resolved per cycle.
// Depends on ptmr_pkg.
`timescale 1ns / 1ps

module ptmr_mag (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [ptmr_pkg::SAMPLE_BITS-1:0] a,
	input  logic signed [ptmr_pkg::SAMPLE_BITS-1:0] b,
	input  logic signed [ptmr_pkg::SAMPLE_BITS-1:0] c,
	output logic                                   done,
	output logic [ptmr_pkg::SAMPLE_BITS-1:0]        root
);

	localparam int SB = ptmr_pkg::SAMPLE_BITS;
	localparam int RB = ptmr_pkg::RAD_BITS;
	localparam int MB = ptmr_pkg::REM_BITS;
	localparam int CB = ptmr_pkg::CNT_BITS;
	localparam logic [CB-1:0] SUM_LAST  = CB'(3);
	localparam logic [CB-1:0] ROOT_LAST = CB'(SB - 1);

	ptmr_pkg::sq_state_t state_q, state_d;

	logic [CB-1:0] cnt_q;
	logic [SB-1:0] comp_q [3];
	logic [RB-1:0] prod_q;
	logic [RB-1:0] rad_q;
	logic [MB-1:0] rem_q;
	logic [SB-1:0] root_q;

	logic [MB-1:0]   rem_sh;
	logic [MB-1:0]   trial;
	logic            fits;
	logic [SB-1:0]   abs_a, abs_b, abs_c;

	function automatic logic [SB-1:0] abs_val(input logic signed [SB-1:0] v);
		logic [SB-1:0] u;
		u = v;
		return v[SB-1] ? (~u + SB'(1)) : u;
	endfunction

	assign abs_a = abs_val(a);
	assign abs_b = abs_val(b);
	assign abs_c = abs_val(c);

	assign rem_sh = {rem_q[MB-3:0], rad_q[RB-1 -: 2]};
	assign trial  = MB'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	assign done = (state_q == ptmr_pkg::SQ_DONE);
	assign root = root_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptmr_pkg::SQ_IDLE, ptmr_pkg::SQ_DONE: begin
				state_d = start ? ptmr_pkg::SQ_SUM : ptmr_pkg::SQ_IDLE;
			end
			ptmr_pkg::SQ_SUM: begin
				if (cnt_q == SUM_LAST) state_d = ptmr_pkg::SQ_ROOT;
			end
			ptmr_pkg::SQ_ROOT: begin
				if (cnt_q == ROOT_LAST) state_d = ptmr_pkg::SQ_DONE;
			end
			default: state_d = ptmr_pkg::SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptmr_pkg::SQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ptmr_pkg::SQ_IDLE, ptmr_pkg::SQ_DONE: begin
				if (start) begin
					comp_q[0] <= abs_a;
					comp_q[1] <= abs_b;
					comp_q[2] <= abs_c;
					prod_q    <= '0;
					rad_q     <= '0;
					rem_q     <= '0;
					root_q    <= '0;
				end
			end
			ptmr_pkg::SQ_SUM: begin
				// Square one component while the previous square accumulates.
				prod_q    <= comp_q[0] * comp_q[0];
				comp_q[0] <= comp_q[1];
				comp_q[1] <= comp_q[2];
				comp_q[2] <= '0;
				rad_q     <= rad_q + prod_q;
			end
			ptmr_pkg::SQ_ROOT: begin
				rad_q <= {rad_q[RB-3:0], 2'b00};
				if (fits) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[SB-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[SB-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

endmodule
